// ===== sv/pargb_pkg.sv =====
// Shared types, constants and the divider step for the premultiplied ARGB to RGB block.
package pargb_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned NUM_CH      = 3;
  localparam int unsigned CH_IDX_W    = 2;
  localparam int unsigned CH_RED      = 0;
  localparam int unsigned CH_GREEN    = 1;
  localparam int unsigned CH_BLUE     = 2;

  // Numerator c*255 fits in 16 bits; quotient has the same width.
  localparam int unsigned NUM_W       = 2 * CHAN_W;
  localparam int unsigned BITS_PER_ST = 2;
  localparam int unsigned DIV_STAGES  = NUM_W / BITS_PER_ST;

  // Input register, divider stages, alpha multiply, output register.
  localparam int unsigned NUM_STAGES  = DIV_STAGES + 3;
  localparam int unsigned MUL_ST      = DIV_STAGES + 1;
  localparam int unsigned OUT_ST      = DIV_STAGES + 2;

  // floor(y/255) = (y * ceil(2^32/255)) >> 32, exact for y < 2^24.
  localparam int unsigned Y_W         = NUM_W + CHAN_W;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [RECIP_W-1:0] RECIP_255 = 25'd16843010;
  localparam int unsigned PROD_W      = Y_W + RECIP_W;

  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

  typedef logic [CHAN_W-1:0] chan_t;

  // One divider stage: running remainder and numerator/quotient shift register per channel.
  typedef struct packed {
    logic                          zero;
    chan_t                         alpha;
    logic [NUM_CH-1:0][CHAN_W-1:0] rem;
    logic [NUM_CH-1:0][NUM_W-1:0]  nq;
  } div_st_t;

  // c*255 as a shift and subtract.
  function automatic logic [NUM_W-1:0] times_255(chan_t c);
    return {c, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, c};
  endfunction

  // Two restoring division steps on every channel.
  function automatic div_st_t div_step(div_st_t s);
    div_st_t          r;
    logic [CHAN_W:0]  t;
    r = s;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int b = 0; b < BITS_PER_ST; b++) begin
        t = {r.rem[ch], r.nq[ch][NUM_W-1]};
        r.nq[ch] = {r.nq[ch][NUM_W-2:0], 1'b0};
        if (t >= {1'b0, r.alpha}) begin
          t = t - {1'b0, r.alpha};
          r.nq[ch][0] = 1'b1;
        end
        r.rem[ch] = t[CHAN_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ===== sv/pargb_in_if.sv =====
// Input channel: one premultiplied ARGB pixel per beat.
interface pargb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] alpha_in;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, alpha_in, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, alpha_in, red_in, green_in, blue_in, output ready);
endinterface

// ===== sv/pargb_out_if.sv =====
// Output channel: one opaque RGB pixel per beat.
interface pargb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== sv/premult_argb_to_rgb_over_white.sv =====
// Top level: premultiplied ARGB pixel to opaque RGB composited over white.
//
// pix_in carries one premultiplied ARGB pixel per beat, pix_out one RGB pixel
// per beat, both valid/ready; a beat moves when valid and ready are high.
// Each color channel is un-premultiplied as floor(c*255/a) and blended over
// white as (255-a) + floor(u*a/255), low 8 bits kept. Alpha 0 gives white.
//
// From input beat to output valid a pixel passes one input register, eight
// divider stages resolving two quotient bits each, one alpha multiply stage
// and one output register doing the reciprocal multiply by 1/255. Throughput is
// one pixel per clock unless pix_out stalls; the three channels run in parallel.
//
// The whole pipeline advances together whenever the output register is empty
// or pix_out.ready is high. When the receiver stalls with a result waiting,
// every stage holds and pix_in.ready drops; nothing is lost or repeated.
// Synchronous reset clears all stage valid bits; the datapath is not reset.
module premult_argb_to_rgb_over_white (
  input  logic         clk,
  input  logic         rst,
  pargb_in_if.sink     pix_in,
  pargb_out_if.source  pix_out
);
  import pargb_pkg::*;

  logic [NUM_STAGES-1:0]          vld;
  logic                           adv;
  div_st_t                        ds [DIV_STAGES+1];
  logic                           m_zero;
  chan_t                          m_alpha;
  logic [NUM_CH-1:0][Y_W-1:0]     m_y;
  logic [NUM_CH-1:0][PROD_W-1:0]  prod;
  logic [NUM_CH-1:0][CHAN_W-1:0]  res;
  logic [NUM_CH-1:0][CHAN_W-1:0]  pix_res;
  logic [NUM_CH-1:0][CHAN_W-1:0]  pix_c;

  // Pipeline advances when the output register is free or being drained
  assign adv          = !vld[OUT_ST] || pix_out.ready;
  assign pix_in.ready = adv;

  assign pix_c[CH_RED]   = pix_in.red_in;
  assign pix_c[CH_GREEN] = pix_in.green_in;
  assign pix_c[CH_BLUE]  = pix_in.blue_in;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STAGES-2:0], pix_in.valid};
    end
  end

  // Reciprocal multiply for floor(y/255) and the blend with white
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = {{RECIP_W{1'b0}}, m_y[ch]} * {{Y_W{1'b0}}, RECIP_255};
      res[ch]  = m_zero ? CHAN_MAX
               : (~m_alpha) + prod[ch][RECIP_SHIFT +: CHAN_W];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      // input register: flag transparent pixels, form c*255
      ds[0].zero  <= (pix_in.alpha_in == '0);
      ds[0].alpha <= pix_in.alpha_in;
      ds[0].rem   <= '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        ds[0].nq[ch] <= times_255(pix_c[ch]);
      end
      // divider stages
      for (int k = 1; k <= DIV_STAGES; k++) begin
        ds[k] <= div_step(ds[k-1]);
      end
      // u * a
      m_zero  <= ds[DIV_STAGES].zero;
      m_alpha <= ds[DIV_STAGES].alpha;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        m_y[ch] <= {{CHAN_W{1'b0}}, ds[DIV_STAGES].nq[ch]}
                 * {{NUM_W{1'b0}}, ds[DIV_STAGES].alpha};
      end
      // output register
      pix_res <= res;
    end
  end

  assign pix_out.valid     = vld[OUT_ST];
  assign pix_out.red_out   = pix_res[CH_RED];
  assign pix_out.green_out = pix_res[CH_GREEN];
  assign pix_out.blue_out  = pix_res[CH_BLUE];

endmodule

// ===== sv/pargb_checker.sv =====
// Port-level checker for the premultiplied ARGB to RGB block, with its bind.
module pargb_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out
);

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A waiting result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(red_out) && $stable(green_out) && $stable(blue_out))
    else $error("output beat changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  // Pipeline never blocks input while the receiver takes results
  a_flow: assert property (@(posedge clk)
    out_ready |-> in_ready)
    else $error("input stalled with receiver ready");

  // An offered input beat is taken while the output register is empty
  a_in_flow: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

bind premult_argb_to_rgb_over_white pargb_checker u_pargb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red_out   (pix_out.red_out),
  .green_out (pix_out.green_out),
  .blue_out  (pix_out.blue_out)
);

// ===== tb/premult_argb_to_rgb_over_white_test.sv =====
// Testbench for premult_argb_to_rgb_over_white: random and corner pixels, checked against a predictor.
module premult_argb_to_rgb_over_white_test;
  import pargb_pkg::*;

  typedef struct packed {
    chan_t alpha;
    chan_t red;
    chan_t green;
    chan_t blue;
  } argb_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // Keeps the composited pixels still owed by the block, oldest first
  class composite_checker;
    rgb_t        expected_rgb[$];
    int unsigned errors;
    int unsigned n_checked;
    int unsigned n_transparent;
    int unsigned n_opaque;
    int unsigned n_above_alpha;

    function new();
      errors        = 0;
      n_checked     = 0;
      n_transparent = 0;
      n_opaque      = 0;
      n_above_alpha = 0;
    endfunction

    // Un-premultiply one channel, then blend it over white; wraps to 8 bits
    function chan_t over_white(chan_t c, chan_t a);
      int unsigned full;
      int unsigned unmul;
      int unsigned blended;
      full = CHAN_MAX;
      if (a == CHAN_MAX) return c;
      unmul   = (int'(c) * full) / int'(a);
      blended = (unmul * int'(a) + full * (full - int'(a))) / full;
      return chan_t'(blended);
    endfunction

    function void note_pixel(argb_t p);
      rgb_t e;
      if (p.alpha == '0) begin
        e = '{CHAN_MAX, CHAN_MAX, CHAN_MAX};
        n_transparent++;
      end else begin
        e.red   = over_white(p.red, p.alpha);
        e.green = over_white(p.green, p.alpha);
        e.blue  = over_white(p.blue, p.alpha);
        if (p.alpha == CHAN_MAX) n_opaque++;
        else if (p.red > p.alpha || p.green > p.alpha || p.blue > p.alpha) n_above_alpha++;
      end
      expected_rgb.push_back(e);
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t e;
      if (expected_rgb.size() == 0) begin
        $display("%0t: unexpected result beat r=%0d g=%0d b=%0d",
                 $time, got.red, got.green, got.blue);
        errors++;
        return;
      end
      e = expected_rgb.pop_front();
      n_checked++;
      if (got.red !== e.red) begin
        $display("%0t: red mismatch, expected %0d, got %0d", $time, e.red, got.red);
        errors++;
      end
      if (got.green !== e.green) begin
        $display("%0t: green mismatch, expected %0d, got %0d", $time, e.green, got.green);
        errors++;
      end
      if (got.blue !== e.blue) begin
        $display("%0t: blue mismatch, expected %0d, got %0d", $time, e.blue, got.blue);
        errors++;
      end
    endfunction

    function int pending();
      return expected_rgb.size();
    endfunction
  endclass

  localparam int N_RANDOM    = 1080;
  localparam int HOLD_AT     = 300;
  localparam int PAUSE_AT    = 700;
  localparam int QUIET_FROM  = N_RANDOM - 150;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 3 * NUM_STAGES;

  logic clk;
  logic rst;

  pargb_in_if  pix_in();
  pargb_out_if pix_out();

  premult_argb_to_rgb_over_white dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

  composite_checker sb;

  // Shared flags between the sender and the receiver
  bit quiet;
  bit hold_req;
  bit hold_active;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("timeout: %0d results still outstanding", sb.pending());
    $display("[premult_argb_to_rgb_over_white] ERROR");
    $finish;
  end

  // Score accepted beats on both channels
  always @(posedge clk) begin
    if (!rst && pix_in.valid && pix_in.ready)
      sb.note_pixel('{pix_in.alpha_in, pix_in.red_in, pix_in.green_in, pix_in.blue_in});
    if (!rst && pix_out.valid && pix_out.ready)
      sb.check_pixel('{pix_out.red_out, pix_out.green_out, pix_out.blue_out});
  end

  // Receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    int n;
    wait (rst === 1'b0);
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        pix_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else if (quiet) begin
        pix_out.ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 11);
        pix_out.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = $urandom_range(1, 24);
        pix_out.ready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  // Offer one pixel and hold it until the block takes it
  task automatic send_pixel(input argb_t p);
    int n;
    if (!quiet && !hold_active && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      pix_in.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    pix_in.valid    <= 1'b1;
    pix_in.alpha_in <= p.alpha;
    pix_in.red_in   <= p.red;
    pix_in.green_in <= p.green;
    pix_in.blue_in  <= p.blue;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  // Let a clock edge pass first so the last accepted beat is already on the scoreboard
  task automatic drain_expected();
    pix_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic argb_t random_pixel();
    argb_t p;
    int    mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      // corner alphas with any color
      case ($urandom_range(0, 3))
        0: p.alpha = 8'd0;
        1: p.alpha = 8'd1;
        2: p.alpha = 8'd254;
        default: p.alpha = CHAN_MAX;
      endcase
      p.red   = chan_t'($urandom_range(0, 255));
      p.green = chan_t'($urandom_range(0, 255));
      p.blue  = chan_t'($urandom_range(0, 255));
    end else if (mode == 1) begin
      // unconstrained, channels may exceed alpha
      p = argb_t'($urandom);
    end else begin
      // well-formed premultiplied pixel
      p.alpha = chan_t'($urandom_range(1, 255));
      p.red   = chan_t'($urandom_range(0, p.alpha));
      p.green = chan_t'($urandom_range(0, p.alpha));
      p.blue  = chan_t'($urandom_range(0, p.alpha));
    end
    return p;
  endfunction

  // Main sequence
  initial begin
    argb_t directed[$];
    sb          = new();
    quiet       = 1'b0;
    hold_req    = 1'b0;
    hold_active = 1'b0;
    rst             <= 1'b1;
    pix_in.valid    <= 1'b0;
    pix_in.alpha_in <= '0;
    pix_in.red_in   <= '0;
    pix_in.green_in <= '0;
    pix_in.blue_in  <= '0;
    pix_out.ready   <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // transparent: colors ignored
    directed.push_back(32'h00000000);
    directed.push_back(32'h00FFFFFF);
    directed.push_back(32'h00123456);
    // opaque: pass-through
    directed.push_back(32'hFF000000);
    directed.push_back(32'hFFFFFFFF);
    directed.push_back(32'hFFA55A3C);
    // smallest and largest partial alpha, including channels above alpha
    directed.push_back(32'h010001FF);
    directed.push_back(32'h01010101);
    directed.push_back(32'hFEFE00FF);
    directed.push_back(32'hFE7F8001);
    // mid alphas, channel equal to, just under and over alpha
    directed.push_back(32'h80804000);
    directed.push_back(32'h80FF817F);
    directed.push_back(32'h403F4041);
    directed.push_back(32'h7F55AA7F);
    directed.push_back(32'hC0C001BF);
    directed.push_back(32'h10F00FAA);
    foreach (directed[i]) send_pixel(directed[i]);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == HOLD_AT) hold_req = 1'b1;
      if (i == PAUSE_AT) drain_expected();
      if (i == QUIET_FROM) quiet = 1'b1;
      send_pixel(random_pixel());
    end

    drain_expected();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d pixels: %0d transparent, %0d opaque, %0d with a channel above alpha",
             sb.n_checked, sb.n_transparent, sb.n_opaque, sb.n_above_alpha);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[premult_argb_to_rgb_over_white] OK");
    end else begin
      $display("%0d mismatches, %0d results left over", sb.errors, sb.pending());
      $display("[premult_argb_to_rgb_over_white] ERROR");
    end
    $finish;
  end

endmodule
